// ===== rtl/dspv_pkg.sv =====
`timescale 1ns / 1ps

package dspv_pkg;

  localparam int unsigned CHAR_W  = 8;
  localparam int unsigned MONTH_W = 8;
  localparam int unsigned DAY_W   = 8;
  localparam int unsigned YEAR_W  = 16;
  localparam int unsigned REG_W   = 14;
  localparam int unsigned ADDR_W  = 2;
  localparam int unsigned MLEN_W  = 5;

  // Result status codes.
  localparam logic [1:0] ST_VALID   = 2'd0;
  localparam logic [1:0] ST_INVALID = 2'd1;
  localparam logic [1:0] ST_EMPTY   = 2'd2;

  // Configuration register indexes.
  localparam logic [ADDR_W-1:0] CFG_YEAR_LOW     = 2'd0;
  localparam logic [ADDR_W-1:0] CFG_YEAR_HIGH    = 2'd1;
  localparam logic [ADDR_W-1:0] CFG_CENTURY_BASE = 2'd2;

  localparam logic [REG_W-1:0] YEAR_LOW_RST     = 14'd1980;
  localparam logic [REG_W-1:0] YEAR_HIGH_RST    = 14'd2099;
  localparam logic [REG_W-1:0] CENTURY_BASE_RST = 14'd1900;

  localparam logic [CHAR_W-1:0] CH_NUL   = 8'h00;
  localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;
  localparam logic [CHAR_W-1:0] CH_SLASH = 8'h2F;
  localparam logic [CHAR_W-1:0] CH_DOT   = 8'h2E;
  localparam logic [CHAR_W-1:0] CH_DASH  = 8'h2D;

  localparam logic [YEAR_W-1:0] TWO_DIGIT_MAX = 16'd99;

  // 25 * INV25 == 1 (mod 2^16). A 16-bit value is a multiple of 25 exactly
  // when its product with INV25, taken mod 2^16, is at most 65535 / 25.
  localparam logic [YEAR_W-1:0] INV25     = 16'd23593;
  localparam logic [YEAR_W-1:0] DIV25_MAX = 16'd2621;

  localparam logic [MONTH_W-1:0] FEBRUARY = 8'd2;
  localparam logic [DAY_W-1:0]   LEAP_DAY = 8'd29;

  typedef enum logic [1:0] {
    PH_MONTH,
    PH_DAY,
    PH_YEAR,
    PH_IGNORE
  } phase_t;

  typedef struct packed {
    logic [REG_W-1:0] year_low;
    logic [REG_W-1:0] year_high;
    logic [REG_W-1:0] century_base;
  } cfg_t;

  // One finished string as it leaves the parser.
  typedef struct packed {
    logic               empty;
    logic               syn_fail;
    logic [MONTH_W-1:0] month;
    logic [DAY_W-1:0]   day;
    logic [YEAR_W-1:0]  year;
  } snap_t;

  // Partial checks, registered ahead of the final leap-year decision.
  typedef struct packed {
    logic               empty;
    logic               syn_fail;
    logic [MONTH_W-1:0] month;
    logic [DAY_W-1:0]   day;
    logic [YEAR_W-1:0]  year;
    logic [YEAR_W-1:0]  prod25;
    logic               range_ok;
    logic               day_std_ok;
    logic               feb29;
    logic               div4;
    logic               div16;
  } chk_t;

  // Days in a month of a common year; zero for a month out of range.
  function automatic logic [MLEN_W-1:0] month_len(input logic [MONTH_W-1:0] m);
    logic [MLEN_W-1:0] len;
    case (m)
      8'd1, 8'd3, 8'd5, 8'd7, 8'd8, 8'd10, 8'd12: len = 5'd31;
      8'd4, 8'd6, 8'd9, 8'd11:                    len = 5'd30;
      8'd2:                                       len = 5'd28;
      default:                                    len = 5'd0;
    endcase
    return len;
  endfunction

endpackage

// ===== rtl/dspv_regs.sv =====
`timescale 1ns / 1ps

module dspv_regs (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_wr_en,
  input  logic [dspv_pkg::ADDR_W-1:0] cfg_addr,
  input  logic [dspv_pkg::REG_W-1:0]  cfg_wdata,
  output dspv_pkg::cfg_t              cfg
);

  dspv_pkg::cfg_t cfg_r;
  dspv_pkg::cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_wr_en) begin
      unique case (cfg_addr)
        dspv_pkg::CFG_YEAR_LOW:     cfg_nxt.year_low     = cfg_wdata;
        dspv_pkg::CFG_YEAR_HIGH:    cfg_nxt.year_high    = cfg_wdata;
        dspv_pkg::CFG_CENTURY_BASE: cfg_nxt.century_base = cfg_wdata;
        default:                    cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.year_low     <= dspv_pkg::YEAR_LOW_RST;
      cfg_r.year_high    <= dspv_pkg::YEAR_HIGH_RST;
      cfg_r.century_base <= dspv_pkg::CENTURY_BASE_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

// ===== rtl/dspv_parser.sv =====
`timescale 1ns / 1ps

module dspv_parser (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_tvalid,
  output logic                        in_tready,
  input  logic [dspv_pkg::CHAR_W-1:0] in_char,
  input  logic                        snap_ready,
  output logic                        snap_valid,
  output dspv_pkg::snap_t             snap
);

  dspv_pkg::phase_t phase_r, phase_nxt;
  logic at_start_r, at_start_nxt;
  logic has_digit_r, has_digit_nxt;
  logic syn_fail_r, syn_fail_nxt;
  logic [dspv_pkg::MONTH_W-1:0] month_r, month_nxt;
  logic [dspv_pkg::DAY_W-1:0]   day_r, day_nxt;
  logic [dspv_pkg::YEAR_W-1:0]  year_r, year_nxt;
  logic            snap_valid_r;
  dspv_pkg::snap_t snap_r;

  logic        accept, term, digit, sep;
  logic [3:0]  dval;
  logic [11:0] month_mac, day_mac;
  logic [19:0] year_mac;
  logic [dspv_pkg::MONTH_W-1:0] month_sat;
  logic [dspv_pkg::DAY_W-1:0]   day_sat;
  logic [dspv_pkg::YEAR_W-1:0]  year_sat;

  assign in_tready = !snap_valid_r || snap_ready;
  assign accept    = in_tvalid && in_tready;
  assign term      = (in_char == dspv_pkg::CH_NUL);
  assign digit     = (in_char >= dspv_pkg::CH_ZERO) && (in_char <= dspv_pkg::CH_NINE);
  assign sep       = (in_char == dspv_pkg::CH_SLASH) || (in_char == dspv_pkg::CH_DOT) ||
                     (in_char == dspv_pkg::CH_DASH);
  assign dval      = digit ? 4'(in_char - dspv_pkg::CH_ZERO) : 4'd0;

  // Times ten plus the new digit, as shifts and adds, then saturate.
  assign month_mac = {1'b0, month_r, 3'b000} + {3'b000, month_r, 1'b0} + {8'd0, dval};
  assign day_mac   = {1'b0, day_r, 3'b000} + {3'b000, day_r, 1'b0} + {8'd0, dval};
  assign year_mac  = {1'b0, year_r, 3'b000} + {3'b000, year_r, 1'b0} + {16'd0, dval};
  assign month_sat = (month_mac > 12'd255) ? 8'hFF : month_mac[7:0];
  assign day_sat   = (day_mac > 12'd255) ? 8'hFF : day_mac[7:0];
  assign year_sat  = (year_mac > 20'd65535) ? 16'hFFFF : year_mac[15:0];

  // Next phase.
  always_comb begin
    phase_nxt = phase_r;
    if (accept) begin
      if (term) begin
        phase_nxt = dspv_pkg::PH_MONTH;
      end else begin
        unique case (phase_r)
          dspv_pkg::PH_MONTH: begin
            if (!digit) begin
              phase_nxt = (sep && has_digit_r) ? dspv_pkg::PH_DAY : dspv_pkg::PH_IGNORE;
            end
          end
          dspv_pkg::PH_DAY: begin
            if (!digit) begin
              phase_nxt = (sep && has_digit_r) ? dspv_pkg::PH_YEAR : dspv_pkg::PH_IGNORE;
            end
          end
          dspv_pkg::PH_YEAR: begin
            if (!digit) begin
              phase_nxt = dspv_pkg::PH_IGNORE;
            end
          end
          default: phase_nxt = phase_r;
        endcase
      end
    end
  end

  // Accumulators and flags.
  always_comb begin
    at_start_nxt  = at_start_r;
    has_digit_nxt = has_digit_r;
    syn_fail_nxt  = syn_fail_r;
    month_nxt     = month_r;
    day_nxt       = day_r;
    year_nxt      = year_r;
    if (accept) begin
      if (term) begin
        at_start_nxt  = 1'b1;
        has_digit_nxt = 1'b0;
        syn_fail_nxt  = 1'b0;
        month_nxt     = '0;
        day_nxt       = '0;
        year_nxt      = '0;
      end else begin
        at_start_nxt = 1'b0;
        unique case (phase_r)
          dspv_pkg::PH_MONTH: begin
            if (digit) begin
              month_nxt     = month_sat;
              has_digit_nxt = 1'b1;
            end else if (sep && has_digit_r) begin
              has_digit_nxt = 1'b0;
            end else begin
              syn_fail_nxt = 1'b1;
            end
          end
          dspv_pkg::PH_DAY: begin
            if (digit) begin
              day_nxt       = day_sat;
              has_digit_nxt = 1'b1;
            end else if (sep && has_digit_r) begin
              has_digit_nxt = 1'b0;
            end
          end
          dspv_pkg::PH_YEAR: begin
            if (digit) begin
              year_nxt      = year_sat;
              has_digit_nxt = 1'b1;
            end
          end
          default: has_digit_nxt = has_digit_r;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= dspv_pkg::PH_MONTH;
      at_start_r   <= 1'b1;
      has_digit_r  <= 1'b0;
      syn_fail_r   <= 1'b0;
      month_r      <= '0;
      day_r        <= '0;
      year_r       <= '0;
      snap_valid_r <= 1'b0;
    end else begin
      phase_r     <= phase_nxt;
      at_start_r  <= at_start_nxt;
      has_digit_r <= has_digit_nxt;
      syn_fail_r  <= syn_fail_nxt;
      month_r     <= month_nxt;
      day_r       <= day_nxt;
      year_r      <= year_nxt;
      if (in_tready) begin
        snap_valid_r <= accept && term;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && term) begin
      snap_r.empty    <= at_start_r;
      snap_r.syn_fail <= syn_fail_r;
      snap_r.month    <= month_r;
      snap_r.day      <= day_r;
      snap_r.year     <= year_r;
    end
  end

  assign snap_valid = snap_valid_r;
  assign snap       = snap_r;

endmodule

// ===== rtl/dspv_check.sv =====
`timescale 1ns / 1ps

module dspv_check (
  input  logic                           clk,
  input  logic                           rst_n,
  input  dspv_pkg::cfg_t                 cfg,
  input  logic                           snap_valid,
  output logic                           snap_ready,
  input  dspv_pkg::snap_t                snap,
  output logic                           res_valid,
  input  logic                           res_ready,
  output logic [1:0]                     res_status,
  output logic [dspv_pkg::MONTH_W-1:0]   res_month,
  output logic [dspv_pkg::DAY_W-1:0]     res_day,
  output logic [dspv_pkg::YEAR_W-1:0]    res_year
);

  // Stage B: year after century expansion.
  logic            vb_r;
  dspv_pkg::snap_t b_r, b_nxt;
  // Stage C: registered partial checks.
  logic            vc_r;
  dspv_pkg::chk_t  c_r, c_nxt;
  // Result register.
  logic                         vo_r;
  logic [1:0]                   status_r, status_nxt;
  logic [dspv_pkg::MONTH_W-1:0] month_r;
  logic [dspv_pkg::DAY_W-1:0]   day_r;
  logic [dspv_pkg::YEAR_W-1:0]  year_r;

  logic o_ready, c_ready, b_ready;
  logic [dspv_pkg::YEAR_W-1:0] prod25;
  logic [dspv_pkg::MLEN_W-1:0] mlen;
  logic div25, leap, date_ok;

  assign o_ready    = !vo_r || res_ready;
  assign c_ready    = !vc_r || o_ready;
  assign b_ready    = !vb_r || c_ready;
  assign snap_ready = b_ready;

  always_comb begin
    b_nxt = snap;
    if (!snap.empty && !snap.syn_fail && (snap.year <= dspv_pkg::TWO_DIGIT_MAX)) begin
      // Small year plus a 14-bit base cannot pass 16 bits.
      b_nxt.year = snap.year + {2'b00, cfg.century_base};
    end
  end

  // Only the low 16 bits of the product matter for the divisibility test.
  assign prod25 = b_r.year * dspv_pkg::INV25;
  assign mlen   = dspv_pkg::month_len(b_r.month);

  always_comb begin
    c_nxt.empty      = b_r.empty;
    c_nxt.syn_fail   = b_r.syn_fail;
    c_nxt.month      = b_r.month;
    c_nxt.day        = b_r.day;
    c_nxt.year       = b_r.year;
    c_nxt.prod25     = prod25;
    c_nxt.range_ok   = (b_r.year >= {2'b00, cfg.year_low}) &&
                       (b_r.year <= {2'b00, cfg.year_high});
    c_nxt.day_std_ok = (b_r.day != '0) && (b_r.day <= {3'b000, mlen});
    c_nxt.feb29      = (b_r.month == dspv_pkg::FEBRUARY) && (b_r.day == dspv_pkg::LEAP_DAY);
    c_nxt.div4       = (b_r.year[1:0] == 2'b00);
    c_nxt.div16      = (b_r.year[3:0] == 4'b0000);
  end

  // Leap year: divisible by 4 and not by 100, or divisible by 400.
  assign div25   = (c_r.prod25 <= dspv_pkg::DIV25_MAX);
  assign leap    = c_r.div4 && (!div25 || c_r.div16);
  assign date_ok = c_r.range_ok && (c_r.day_std_ok || (c_r.feb29 && leap));

  always_comb begin
    if (c_r.empty) begin
      status_nxt = dspv_pkg::ST_EMPTY;
    end else if (c_r.syn_fail || !date_ok) begin
      status_nxt = dspv_pkg::ST_INVALID;
    end else begin
      status_nxt = dspv_pkg::ST_VALID;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vb_r <= 1'b0;
      vc_r <= 1'b0;
      vo_r <= 1'b0;
    end else begin
      if (b_ready) begin
        vb_r <= snap_valid;
      end
      if (c_ready) begin
        vc_r <= vb_r;
      end
      if (o_ready) begin
        vo_r <= vc_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (b_ready && snap_valid) begin
      b_r <= b_nxt;
    end
    if (c_ready && vb_r) begin
      c_r <= c_nxt;
    end
    if (o_ready && vc_r) begin
      status_r <= status_nxt;
      month_r  <= c_r.month;
      day_r    <= c_r.day;
      year_r   <= c_r.empty ? '0 : c_r.year;
    end
  end

  assign res_valid  = vo_r;
  assign res_status = status_r;
  assign res_month  = month_r;
  assign res_day    = day_r;
  assign res_year   = year_r;

endmodule

// ===== rtl/date_string_parse_validate.sv =====
`timescale 1ns / 1ps
// Month/day/year date string checker.
// The in_ channel carries one ASCII character per request in in_tdata; a zero
// character ends the string. Digits build the month, day and year fields,
// which are separated by '/', '.' or '-'. Characters are taken back to back
// while in_tready is high. Only the terminator produces a request on the
// out_ channel: a status (valid, invalid or empty) with the parsed month,
// day and year. On its way out that result passes the parser's snapshot
// register, a century-expansion stage, a stage holding the leap-year
// multiply and the range compares, and then the output register.
// A stalled receiver holds the result in the output register; the stages
// behind it keep filling, and characters are still taken until a finished
// string waits in the parser while every later stage is full.
// The cfg_ port writes year_low, year_high and century_base by index; it is
// meant to be used while no string is in flight.
// Reset (rst_n low, synchronous) empties the result pipeline, puts the
// parser at the start of a string and loads the default year window
// 1980 to 2099 with century base 1900.

module date_string_parse_validate (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_tvalid,
  output logic                        in_tready,
  input  logic [7:0]                  in_tdata,   // [7:0] char_code
  output logic                        out_tvalid,
  input  logic                        out_tready,
  // [1:0] status, [9:2] month_out, [17:10] day_out, [33:18] year_out,
  // [39:34] zero
  output logic [39:0]                 out_tdata,
  input  logic                        cfg_wr_en,
  input  logic [dspv_pkg::ADDR_W-1:0] cfg_addr,
  input  logic [dspv_pkg::REG_W-1:0]  cfg_wdata
);

  dspv_pkg::cfg_t  cfg;
  dspv_pkg::snap_t snap;
  logic snap_valid, snap_ready;
  logic [1:0]                   res_status;
  logic [dspv_pkg::MONTH_W-1:0] res_month;
  logic [dspv_pkg::DAY_W-1:0]   res_day;
  logic [dspv_pkg::YEAR_W-1:0]  res_year;

  dspv_regs u_regs (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr_en (cfg_wr_en),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  // Character parser; holds the per-string state and the finished snapshot.
  dspv_parser u_parser (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_char    (in_tdata),
    .snap_ready (snap_ready),
    .snap_valid (snap_valid),
    .snap       (snap)
  );

  // Date checks and the output register.
  dspv_check u_check (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .snap_valid (snap_valid),
    .snap_ready (snap_ready),
    .snap       (snap),
    .res_valid  (out_tvalid),
    .res_ready  (out_tready),
    .res_status (res_status),
    .res_month  (res_month),
    .res_day    (res_day),
    .res_year   (res_year)
  );

  assign out_tdata = {6'd0, res_year, res_day, res_month, res_status};

endmodule

// ===== sim/tb_date_string_parse_validate.sv =====
`timescale 1ns / 1ps

module tb_date_string_parse_validate;
  import dspv_pkg::*;

  // Generous bound on the whole run, even with the heaviest sender gaps and
  // receiver stalls.
  localparam int unsigned CYCLE_LIMIT = 200000;
  // Characters per configuration phase, terminators included; the last string may run past it.
  localparam int unsigned PHASE_CHARS = 80;
  localparam int unsigned NUM_PHASES = 6;
  localparam int unsigned NUM_DIRECTED = 24;
  // Pause once every expected result is back, before a register write or
  // the final verdict.
  localparam int unsigned DRAIN_CYCLES = 8;

  // One parsed date as it appears on the result channel.
  typedef struct packed {
    logic [1:0]  status;
    logic [7:0]  month;
    logic [7:0]  day;
    logic [15:0] year;
  } verdict_t;

  // A directed row either carries a hand-written expectation (pin set) or
  // leaves the expectation to the date predictor.
  typedef struct packed {
    logic     pin;
    verdict_t want;
  } dir_row_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_tvalid = 1'b0;
  logic              in_tready;
  logic [7:0]        in_tdata = '0;    // [7:0] char_code
  logic              out_tvalid;
  logic              out_tready = 1'b0;
  // [1:0] status, [9:2] month_out, [17:10] day_out, [33:18] year_out,
  // [39:34] zero
  logic [39:0]       out_tdata;
  logic              cfg_wr_en = 1'b0;
  logic [ADDR_W-1:0] cfg_addr = '0;
  logic [REG_W-1:0]  cfg_wdata = '0;

  date_string_parse_validate DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Predictor copy of the year window and century base.
  int unsigned yr_low = YEAR_LOW_RST;
  int unsigned yr_high = YEAR_HIGH_RST;
  int unsigned cent_base = CENTURY_BASE_RST;

  // Predictor copy of the parser state.
  phase_t      fld_phase = PH_MONTH;
  bit          fresh = 1'b1;
  bit          fld_digit = 1'b0;
  bit          bad_month = 1'b0;
  int unsigned mon_acc = 0;
  int unsigned day_acc = 0;
  int unsigned yr_acc = 0;

  verdict_t    pending_dates[$];
  logic [7:0]  text_q[$];
  int unsigned mismatches = 0;
  int unsigned cycle_count = 0;
  int unsigned send_gap_pct = 0;
  int unsigned recv_stall_pct = 0;
  verdict_t    got_want;

  // Directed strings. The pinned rows are the ones whose outcome is obvious:
  // century expansion, reset window edges, the empty string, syntax errors and saturation.
  string dir_text [NUM_DIRECTED] = '{
    "", "12/31/99", "1/1/1980", "12.31.2099", "1-1-1979", "1/1/2100",
    "2/29/2000", "2/29/2100", "2/29/2024", "02/29/2023", "0/10/2000",
    "13/1/2000", "4/31/2000", "6/30/80", "\200/1/2000", "1a/2/3",
    "999/999/99999", "5//2000", "5/6x2001", "7/4/1999 junk\377", "7/4/x",
    "3-15-0", "/", "11/30/"
  };

  dir_row_t dir_rows [NUM_DIRECTED] = '{
    '{1'b1, '{ST_EMPTY,   8'd0,   8'd0,   16'd0}},
    '{1'b1, '{ST_VALID,   8'd12,  8'd31,  16'd1999}},
    '{1'b1, '{ST_VALID,   8'd1,   8'd1,   16'd1980}},
    '{1'b1, '{ST_VALID,   8'd12,  8'd31,  16'd2099}},
    '{1'b1, '{ST_INVALID, 8'd1,   8'd1,   16'd1979}},
    '{1'b1, '{ST_INVALID, 8'd1,   8'd1,   16'd2100}},
    '{1'b0, '0},
    '{1'b0, '0},
    '{1'b0, '0},
    '{1'b0, '0},
    '{1'b0, '0},
    '{1'b0, '0},
    '{1'b0, '0},
    '{1'b0, '0},
    '{1'b1, '{ST_INVALID, 8'd0,   8'd0,   16'd0}},
    '{1'b1, '{ST_INVALID, 8'd1,   8'd0,   16'd0}},
    '{1'b1, '{ST_INVALID, 8'd255, 8'd255, 16'd65535}},
    '{1'b1, '{ST_INVALID, 8'd5,   8'd0,   16'd1900}},
    '{1'b1, '{ST_INVALID, 8'd5,   8'd6,   16'd1900}},
    '{1'b0, '0},
    '{1'b0, '0},
    '{1'b0, '0},
    '{1'b1, '{ST_INVALID, 8'd0,   8'd0,   16'd0}},
    '{1'b0, '0}
  };

  // Year window and century base of each random phase. Phase 2 puts the low
  // bound above the high one, so nothing may pass there. Phase 4 draws its
  // settings at random.
  int unsigned ph_low  [NUM_PHASES] = '{1980, 0,    9999, 1900, 0, 50};
  int unsigned ph_high [NUM_PHASES] = '{2099, 9999, 0,    2100, 0, 150};
  int unsigned ph_base [NUM_PHASES] = '{1900, 0,    9900, 2000, 0, 0};

  function automatic int unsigned push_digit(int unsigned acc, int unsigned dv,
                                             int unsigned ceiling);
    int unsigned sum;
    sum = acc * 10 + dv;
    return (sum > ceiling) ? ceiling : sum;
  endfunction

  function automatic int unsigned days_in_month(int unsigned m, bit leap);
    int unsigned n;
    case (m)
      1, 3, 5, 7, 8, 10, 12: n = 31;
      4, 6, 9, 11:           n = 30;
      2:                     n = leap ? 29 : 28;
      default:               n = 0;
    endcase
    return n;
  endfunction

  // Advances the predicted parser by one character. Returns 1 when the
  // character is the terminator, together with the date verdict it produces.
  function automatic bit parse_char(input logic [7:0] c, output verdict_t v);
    bit          is_dig;
    bit          is_sep;
    bit          leap;
    int unsigned dv;
    int unsigned yr;
    int unsigned mlen;
    is_dig = (c >= CH_ZERO) && (c <= CH_NINE);
    is_sep = (c == CH_SLASH) || (c == CH_DOT) || (c == CH_DASH);
    dv = is_dig ? int'(c - CH_ZERO) : 0;
    v = '0;
    if (c != CH_NUL) begin
      fresh = 1'b0;
      case (fld_phase)
        PH_MONTH: begin
          if (is_dig) begin
            mon_acc = push_digit(mon_acc, dv, 255);
            fld_digit = 1'b1;
          end else if (is_sep && fld_digit) begin
            fld_phase = PH_DAY;
            fld_digit = 1'b0;
          end else begin
            // A malformed month kills the whole string.
            bad_month = 1'b1;
            fld_phase = PH_IGNORE;
          end
        end
        PH_DAY: begin
          if (is_dig) begin
            day_acc = push_digit(day_acc, dv, 255);
            fld_digit = 1'b1;
          end else if (is_sep && fld_digit) begin
            fld_phase = PH_YEAR;
            fld_digit = 1'b0;
          end else begin
            fld_phase = PH_IGNORE;
          end
        end
        PH_YEAR: begin
          if (is_dig) begin
            yr_acc = push_digit(yr_acc, dv, 65535);
            fld_digit = 1'b1;
          end else begin
            fld_phase = PH_IGNORE;
          end
        end
        default: ;
      endcase
      return 1'b0;
    end
    if (fresh) begin
      v.status = ST_EMPTY;
    end else if (bad_month) begin
      // No century expansion after a syntax error.
      v.status = ST_INVALID;
      v.month = 8'(mon_acc);
      v.day = 8'(day_acc);
      v.year = 16'(yr_acc);
    end else begin
      yr = yr_acc;
      if (yr <= 99) begin
        yr = yr + cent_base;
        if (yr > 65535) yr = 65535;
      end
      leap = ((yr % 4 == 0) && (yr % 100 != 0)) || (yr % 400 == 0);
      mlen = days_in_month(mon_acc, leap);
      v.status = (mlen != 0 && day_acc >= 1 && day_acc <= mlen &&
                  yr >= yr_low && yr <= yr_high) ? ST_VALID : ST_INVALID;
      v.month = 8'(mon_acc);
      v.day = 8'(day_acc);
      v.year = 16'(yr);
    end
    // Ready for the next string.
    fld_phase = PH_MONTH;
    fresh = 1'b1;
    fld_digit = 1'b0;
    bad_month = 1'b0;
    mon_acc = 0;
    day_acc = 0;
    yr_acc = 0;
    return 1'b1;
  endfunction

  // Offers one character, with random sender gaps in front of it, and feeds
  // it to the predictor once it is taken. A pinned expectation replaces the
  // predicted one for the terminator of a directed row.
  task automatic send_char(input logic [7:0] c, input bit pin, input verdict_t pin_v);
    verdict_t v;
    while ($urandom_range(0, 99) < send_gap_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= c;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    if (parse_char(c, v)) pending_dates.push_back(pin ? pin_v : v);
  endtask

  // Registers are written only while nothing is in flight, so the predictor
  // may take the new value at once.
  task automatic write_reg(input logic [ADDR_W-1:0] idx, input int unsigned val);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= REG_W'(val);
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    case (idx)
      CFG_YEAR_LOW:     yr_low = val & 16'h3FFF;
      CFG_YEAR_HIGH:    yr_high = val & 16'h3FFF;
      CFG_CENTURY_BASE: cent_base = val & 16'h3FFF;
      default: ;
    endcase
  endtask

  // Waits until every predicted date has come back, then lets the pipeline
  // run dry.
  task automatic drain_results();
    while (pending_dates.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic push_dec(input int unsigned val, input int unsigned min_dig);
    logic [7:0]  digs[$];
    int unsigned rest;
    rest = val;
    do begin
      digs.push_front(8'(CH_ZERO + rest % 10));
      rest = rest / 10;
    end while (rest != 0);
    while (digs.size() < min_dig) digs.push_front(CH_ZERO);
    foreach (digs[i]) text_q.push_back(digs[i]);
  endtask

  function automatic logic [7:0] any_sep();
    logic [7:0] s;
    case ($urandom_range(0, 2))
      0:       s = CH_SLASH;
      1:       s = CH_DOT;
      default: s = CH_DASH;
    endcase
    return s;
  endfunction

  // Builds one random string without its terminator. Most strings are
  // well-formed dates with random content so the range and month-length
  // checks get exercised; the rest are truncated or corrupted dates, pure
  // noise and empty strings.
  task automatic build_random_text();
    int unsigned kind;
    int unsigned r;
    int unsigned m;
    int unsigned dd;
    int unsigned y;
    int unsigned n;
    text_q.delete();
    kind = $urandom_range(0, 99);
    if (kind >= 95) return;
    if (kind >= 85) begin
      n = $urandom_range(1, 8);
      repeat (n) text_q.push_back(8'($urandom_range(1, 255)));
      return;
    end
    r = $urandom_range(0, 99);
    m = (r < 85) ? $urandom_range(1, 12) :
        (r < 95) ? $urandom_range(0, 99) : $urandom_range(100, 999);
    r = $urandom_range(0, 99);
    dd = (r < 80) ? $urandom_range(1, 31) :
         (r < 95) ? $urandom_range(0, 99) : $urandom_range(100, 999);
    // Push February 29 often enough to hit every leap rule.
    if ($urandom_range(0, 9) == 0) begin
      m = 2;
      dd = 29;
    end
    r = $urandom_range(0, 99);
    if (r < 35)      y = $urandom_range(0, 99);
    else if (r < 80) y = $urandom_range(1890, 2110);
    else if (r < 90) y = $urandom_range(0, 9999);
    else if (r < 95) y = $urandom_range(0, 99) * 100;
    else             y = $urandom_range(10000, 999999);
    push_dec(m, $urandom_range(1, 2));
    text_q.push_back(any_sep());
    push_dec(dd, $urandom_range(1, 2));
    text_q.push_back(any_sep());
    push_dec(y, (y < 100) ? $urandom_range(1, 2) : $urandom_range(1, 4));
    if ($urandom_range(0, 99) < 15) begin
      n = $urandom_range(1, 4);
      repeat (n) text_q.push_back(8'($urandom_range(1, 255)));
    end
    if (kind >= 70) begin
      if ($urandom_range(0, 1) == 0) begin
        n = $urandom_range(0, text_q.size() - 1);
        while (text_q.size() > n) void'(text_q.pop_back());
      end else begin
        text_q[$urandom_range(0, text_q.size() - 1)] = 8'($urandom_range(1, 255));
      end
    end
  endtask

  // The receiver stalls at random according to the current phase.
  always @(posedge clk) begin
    out_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  function automatic void check_field(input string name, input int unsigned want,
                                      input int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endfunction

  // Every accepted result is compared with the oldest predicted date.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_dates.size() == 0) begin
        $error("result with nothing expected: %h", out_tdata);
        mismatches++;
      end else begin
        got_want = pending_dates.pop_front();
        check_field("status", got_want.status, out_tdata[1:0]);
        check_field("month_out", got_want.month, out_tdata[9:2]);
        check_field("day_out", got_want.day, out_tdata[17:10]);
        check_field("year_out", got_want.year, out_tdata[33:18]);
        check_field("padding", 0, out_tdata[39:34]);
      end
    end
  end

  // Watchdog: a hung handshake ends the run as a failure.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    int unsigned sent;
    int unsigned lo;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed strings run against the reset year window with no idling.
    for (int r = 0; r < NUM_DIRECTED; r++) begin
      for (int i = 0; i < dir_text[r].len(); i++) send_char(dir_text[r][i], 1'b0, '0);
      send_char(CH_NUL, dir_rows[r].pin, dir_rows[r].want);
    end
    in_tvalid <= 1'b0;
    drain_results();

    // Random phases. Each one sets its own window and idling pattern; the
    // idling cycles through none, sender gaps, receiver stalls and both.
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      if (ph == 4) begin
        lo = $urandom_range(0, 9999);
        write_reg(CFG_YEAR_LOW, lo);
        write_reg(CFG_YEAR_HIGH, $urandom_range(lo, 9999));
        write_reg(CFG_CENTURY_BASE, $urandom_range(0, 99) * 100);
      end else begin
        write_reg(CFG_YEAR_LOW, ph_low[ph]);
        write_reg(CFG_YEAR_HIGH, ph_high[ph]);
        write_reg(CFG_CENTURY_BASE, ph_base[ph]);
      end
      case (ph % 4)
        0: begin send_gap_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_gap_pct = 55; recv_stall_pct = 0;  end
        2: begin send_gap_pct = 0;  recv_stall_pct = 55; end
        default: begin send_gap_pct = 14; recv_stall_pct = 14; end
      endcase
      sent = 0;
      while (sent < PHASE_CHARS) begin
        build_random_text();
        foreach (text_q[i]) send_char(text_q[i], 1'b0, '0);
        send_char(CH_NUL, 1'b0, '0);
        sent += text_q.size() + 1;
      end
      in_tvalid <= 1'b0;
      drain_results();
    end

    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/dspv_pkg.sv
rtl/dspv_regs.sv
rtl/dspv_parser.sv
rtl/dspv_check.sv
rtl/date_string_parse_validate.sv
sim/tb_date_string_parse_validate.sv
